@@ sv/nkls_pkg.sv @@
// Package: shared widths, payload and control types of the nearest-k list selector.
`timescale 1ns / 1ps
package nkls_pkg;

    localparam int DIST_W = 32;
    localparam int PAGE_W = 32;
    localparam int KEEP_W = 6;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic [PAGE_W-1:0]        page;
    } entry_t;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_INSERT,
        MODE_REPLACE,
        MODE_SHIFT
    } cell_mode_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } sel_state_t;

endpackage

@@ sv/nkls_cand_if.sv @@
// Interface: candidate item channel (valid/ready with distance, page and final mark).
`timescale 1ns / 1ps
interface nkls_cand_if import nkls_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] distance;
    logic [PAGE_W-1:0]        list_page;
    logic                     final_item;

    modport source (output valid, output distance, output list_page, output final_item,
                    input ready);
    modport sink   (input valid, input distance, input list_page, input final_item,
                    output ready);
endinterface

@@ sv/nkls_kept_if.sv @@
// Interface: kept result channel (valid/ready with distance, page and last mark).
`timescale 1ns / 1ps
interface nkls_kept_if import nkls_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] kept_distance;
    logic [PAGE_W-1:0]        kept_page;
    logic                     last_of_run;

    modport source (output valid, output kept_distance, output kept_page, output last_of_run,
                    input ready);
    modport sink   (input valid, input kept_distance, input kept_page, input last_of_run,
                    output ready);
endinterface

@@ sv/nearest_k_list_selector.sv @@
// Top level: streaming selection of the keep_count nearest candidate lists per query.
// Throughput: one candidate item per cycle while collecting; each is sorted into the chain or dropped at acceptance.
// Latency: the first result is valid the cycle after the final item is accepted.
// Drain: one result per cycle from the chain head while kept.ready is high;
// cand.ready stays low until the last result is taken.
// Reset: held count cleared, keep_count set to 1; entry contents undefined until written.
`timescale 1ns / 1ps
module nearest_k_list_selector
    import nkls_pkg::*;
#(
    parameter int MAX_KEPT = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    nkls_cand_if.sink         cand,
    nkls_kept_if.source       kept,
    input  logic              cfg_we,
    input  logic [KEEP_W-1:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int KW = (CW > KEEP_W) ? CW : KEEP_W;

    sel_state_t        state_reg;
    sel_state_t        state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [KEEP_W-1:0] keep_count_reg;
    logic [KW-1:0]     keep_ext;
    logic [KW-1:0]     eff_keep;
    logic              below_keep;
    logic              head_gt;
    logic              last_entry;
    cell_mode_t        mode;
    entry_t            new_entry;
    entry_t            head;

    assign new_entry.distance = cand.distance;
    assign new_entry.page     = cand.list_page;

    always_comb
    begin
        keep_ext = KW'(keep_count_reg);
        priority if (keep_ext == '0)
            eff_keep = KW'(1);
        else if (keep_ext > KW'(MAX_KEPT))
            eff_keep = KW'(MAX_KEPT);
        else
            eff_keep = keep_ext;
    end

    assign below_keep = KW'(count_reg) < eff_keep;
    assign head_gt    = head.distance > cand.distance;
    assign last_entry = (count_reg == CW'(1));

    nkls_chain #(
        .DEPTH (MAX_KEPT)
    ) u_chain (
        .clk       (clk),
        .mode      (mode),
        .new_entry (new_entry),
        .count     (count_reg),
        .head      (head)
    );

    assign kept.kept_distance = head.distance;
    assign kept.kept_page     = head.page;
    assign kept.last_of_run   = last_entry;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (cand.valid && cand.final_item)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (kept.ready && last_entry)
                    state_next = ST_COLLECT;
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // outputs and cell control
    always_comb
    begin
        cand.ready = 1'b0;
        kept.valid = 1'b0;
        mode       = MODE_HOLD;
        count_next = count_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                cand.ready = 1'b1;
                if (cand.valid)
                begin
                    priority if (below_keep)
                    begin
                        mode       = MODE_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                    else if (count_reg != '0 && head_gt)
                    begin
                        mode = MODE_REPLACE;
                    end
                    else
                    begin
                        mode = MODE_HOLD;
                    end
                end
            end
            ST_DRAIN:
            begin
                kept.valid = 1'b1;
                if (kept.ready)
                begin
                    mode       = MODE_SHIFT;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                mode = MODE_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            count_reg      <= '0;
            keep_count_reg <= KEEP_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                keep_count_reg <= cfg_wdata;
        end
    end

    a_drain_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (count_reg != '0))
        else $error("drain with no held entry");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (KW'(count_reg) <= KW'(MAX_KEPT)))
        else $error("held count above depth");

    a_final_starts_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (cand.valid && cand.ready && cand.final_item) |=> kept.valid)
        else $error("final item did not start drain");

    a_last_ends_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (kept.valid && kept.ready && kept.last_of_run) |=> (cand.ready && count_reg == '0))
        else $error("last result did not end drain");

    a_sides_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        !(kept.valid && cand.ready))
        else $error("input open during drain");

endmodule

@@ sv/nkls_cell.sv @@
// One compare-and-shift cell: holds one kept entry and trades it with its neighbors.
`timescale 1ns / 1ps
module nkls_cell
    import nkls_pkg::*;
(
    input  logic       clk,
    input  cell_mode_t mode,
    input  logic       cell_valid,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  logic       left_stay,
    input  entry_t     right_entry,
    input  logic       right_stay,
    output entry_t     entry,
    output logic       stay
);

    entry_t entry_reg;
    entry_t entry_next;

    assign entry = entry_reg;
    assign stay  = cell_valid && (entry_reg.distance >= new_entry.distance);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (mode)
            MODE_HOLD:
            begin
                entry_next = entry_reg;
            end
            MODE_INSERT:
            begin
                priority if (stay)
                    entry_next = entry_reg;
                else if (left_stay)
                    entry_next = new_entry;
                else
                    entry_next = left_entry;
            end
            MODE_REPLACE:
            begin
                priority if (right_stay)
                    entry_next = right_entry;
                else if (stay)
                    entry_next = new_entry;
                else
                    entry_next = entry_reg;
            end
            MODE_SHIFT:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ sv/nkls_chain.sv @@
// Row of cells holding the kept entries sorted largest distance first.
`timescale 1ns / 1ps
module nkls_chain
    import nkls_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                       clk,
    input  cell_mode_t                 mode,
    input  entry_t                     new_entry,
    input  logic [$clog2(DEPTH+1)-1:0] count,
    output entry_t                     head
);

    localparam int CW = $clog2(DEPTH + 1);

    entry_t entries [DEPTH];
    logic   stays   [DEPTH];
    logic   valids  [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t left_e;
            logic   left_s;
            entry_t right_e;
            logic   right_s;

            assign valids[i] = (count > CW'(i));

            if (i == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_s = 1'b1;
            end
            else
            begin : g_mid_left
                assign left_e = entries[i-1];
                assign left_s = stays[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_e = new_entry;
                assign right_s = 1'b0;
            end
            else
            begin : g_mid_right
                assign right_e = entries[i+1];
                assign right_s = stays[i+1];
            end

            nkls_cell u_cell (
                .clk         (clk),
                .mode        (mode),
                .cell_valid  (valids[i]),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_stay   (left_s),
                .right_entry (right_e),
                .right_stay  (right_s),
                .entry       (entries[i]),
                .stay        (stays[i])
            );
        end
    endgenerate

    assign head = entries[0];

endmodule
